[rtl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasteriser.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned COORD_BITS = 10;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef struct packed {
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } dda_in_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } dda_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic tick;
    logic div_step;
  } dda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_zero;
    logic div_done;
    logic last_step;
  } dda_sts_t;

endpackage

[rtl/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasteriser: start requests load two endpoints, tick requests
// step along the line one pixel at a time.
// ----------------------------------------------------------------------------
// A taken start request sends its first point straight to the output
// register. Unless both endpoints are equal, the per-step x and y
// increments are then worked out by a restoring divider that produces one
// quotient bit per cycle for both axes at once, and no request is accepted
// until the division is done. Tick requests then yield one pixel per cycle
// while the output is not stalled; the last pixel of a line carries
// last_point. A tick while no line is in progress is taken and gives no
// result. A start while drawing abandons the current line.
module dda_line_rasterizer #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dda_pkg::dda_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dda_pkg::dda_out_t out_rsp_o
);
  import dda_pkg::*;

  dda_cmd_t cmd;
  dda_sts_t sts;

  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_req_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dda_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

  // A stalled result must block new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while result stalled");

  // Every start yields its first point in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.kind == KIND_START) |=> out_valid_o)
    else $error("start produced no point");

  // A start with distinct endpoints holds off requests while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.kind == KIND_START && !sts.step_zero)
      |=> !in_ready_o)
    else $error("request taken during divide");

  // Divider never runs alongside a load or a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !(cmd.load || cmd.tick))
    else $error("divide overlaps request");

endmodule

[rtl/dda_ctrl.sv]
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer for the line rasteriser: handshakes, output valid and the
// idle / divide / draw states.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dda_pkg::dda_sts_t sts_i,
  output dda_pkg::dda_cmd_t cmd_o
);
  import dda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_ready;
  logic       accept;
  dda_cmd_t   cmd;

  // Output register must be free or draining, and no divide running, before a request is taken
  assign in_ready = (state_q != ST_DIV) && (!out_valid_q || out_ready_i);
  assign accept   = in_valid_i && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept && (in_kind_i == KIND_START);
    cmd.tick     = accept && (in_kind_i == KIND_TICK) && (state_q == ST_DRAW);
    cmd.div_step = (state_q == ST_DIV);
  end

  assign out_valid_d = cmd.load || cmd.tick || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd.load && !sts_i.step_zero) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_DRAW;
      end
      ST_DRAW: begin
        if (cmd.load) begin
          state_d = sts_i.step_zero ? ST_IDLE : ST_DIV;
        end else if (cmd.tick && sts_i.last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[rtl/dda_dp.sv]
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: endpoint set-up, restoring divider with a shared divisor for both axes,
// position accumulators and the output register.
// ----------------------------------------------------------------------------
module dda_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dda_pkg::dda_in_t  in_req_i,
  input  dda_pkg::dda_cmd_t cmd_i,
  output dda_pkg::dda_sts_t sts_o,
  output dda_pkg::dda_out_t out_rsp_o
);
  import dda_pkg::*;

  localparam int unsigned POS_W  = COORD_BITS + FRAC_BITS;
  localparam int unsigned INC_W  = FRAC_BITS + 2;
  localparam int unsigned QUO_W  = FRAC_BITS + 1;
  localparam int unsigned STEP_W = COORD_BITS + 1;
  localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);

  // Set-up on a start request
  logic                  neg_x, neg_y;
  logic [COORD_BITS-1:0] abs_x, abs_y, step_w;

  assign neg_x  = in_req_i.end_x < in_req_i.start_x;
  assign neg_y  = in_req_i.end_y < in_req_i.start_y;
  assign abs_x  = neg_x ? in_req_i.start_x - in_req_i.end_x : in_req_i.end_x - in_req_i.start_x;
  assign abs_y  = neg_y ? in_req_i.start_y - in_req_i.end_y : in_req_i.end_y - in_req_i.start_y;
  assign step_w = (abs_x > abs_y) ? abs_x : abs_y;

  // State
  logic [POS_W-1:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [INC_W-1:0]      inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic [STEP_W-1:0]     steps_q, steps_d;
  logic                  neg_x_q, neg_y_q;
  logic [COORD_BITS-1:0] div_q;
  logic [STEP_W-1:0]     rx_q, rx_d, ry_q, ry_d;
  logic [QUO_W-1:0]      qx_q, qx_d, qy_q, qy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  dda_out_t              out_q, out_d;

  // One quotient bit per axis and cycle
  logic                  bit_x, bit_y;
  logic [STEP_W-1:0]     remx, remy;
  logic [INC_W-1:0]      mag_x, mag_y;

  assign bit_x = rx_q >= {1'b0, div_q};
  assign bit_y = ry_q >= {1'b0, div_q};
  assign remx  = bit_x ? rx_q - {1'b0, div_q} : rx_q;
  assign remy  = bit_y ? ry_q - {1'b0, div_q} : ry_q;
  assign qx_d  = {qx_q[QUO_W-2:0], bit_x};
  assign qy_d  = {qy_q[QUO_W-2:0], bit_y};
  assign mag_x = {1'b0, qx_d};
  assign mag_y = {1'b0, qy_d};

  // Accumulator advance
  logic [POS_W-1:0] next_x, next_y;
  assign next_x = pos_x_q + {{(POS_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
  assign next_y = pos_y_q + {{(POS_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    inc_x_d = inc_x_q;
    inc_y_d = inc_y_q;
    steps_d = steps_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    cnt_d   = cnt_q;
    out_d   = out_q;

    if (cmd_i.load) begin
      pos_x_d          = {in_req_i.start_x, {FRAC_BITS{1'b0}}};
      pos_y_d          = {in_req_i.start_y, {FRAC_BITS{1'b0}}};
      steps_d          = {1'b0, step_w};
      rx_d             = {1'b0, abs_x};
      ry_d             = {1'b0, abs_y};
      cnt_d            = CNT_W'(FRAC_BITS);
      out_d.point_x    = in_req_i.start_x;
      out_d.point_y    = in_req_i.start_y;
      out_d.last_point = (step_w == '0);
    end else if (cmd_i.div_step) begin
      // Remainder stays below the divisor, so the shift cannot overflow
      rx_d  = {remx[COORD_BITS-1:0], 1'b0};
      ry_d  = {remy[COORD_BITS-1:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        inc_x_d = neg_x_q ? (~mag_x + 1'b1) : mag_x;
        inc_y_d = neg_y_q ? (~mag_y + 1'b1) : mag_y;
      end
    end else if (cmd_i.tick) begin
      pos_x_d          = next_x;
      pos_y_d          = next_y;
      steps_d          = steps_q - 1'b1;
      out_d.point_x    = next_x[POS_W-1:FRAC_BITS];
      out_d.point_y    = next_y[POS_W-1:FRAC_BITS];
      out_d.last_point = (steps_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      inc_x_q <= '0;
      inc_y_q <= '0;
      steps_q <= '0;
      cnt_q   <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      inc_x_q <= inc_x_d;
      inc_y_q <= inc_y_d;
      steps_q <= steps_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    out_q <= out_d;
    if (cmd_i.load) begin
      neg_x_q <= neg_x;
      neg_y_q <= neg_y;
      div_q   <= step_w;
      qx_q    <= '0;
      qy_q    <= '0;
    end else if (cmd_i.div_step) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.step_zero = (step_w == '0);
    sts_o.div_done  = (cnt_q == '0);
    sts_o.last_step = (steps_q == STEP_W'(1));
  end

  assign out_rsp_o = out_q;

endmodule

[verif/tb_dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Drives start and tick requests into the line rasteriser under random
// back-pressure on both sides, predicts every plotted pixel in fixed point and
// checks each returned point field by field in order.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import dda_pkg::*;

  localparam int unsigned FRAC_BITS           = 16;
  localparam int unsigned POS_W               = COORD_BITS + FRAC_BITS;
  localparam int unsigned INC_W               = FRAC_BITS + 2;
  localparam int          COORD_MAX           = (1 << COORD_BITS) - 1;
  localparam int unsigned ITEM_TARGET         = 650;
  // divider must finish after the last start; leave ample margin
  localparam int unsigned DRAIN_CYCLES        = 40;
  localparam int unsigned BACKPRESSURE_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT      = 2000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dda_in_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dda_out_t out_rsp;

  dda_in_t     pending_requests[$];
  dda_out_t    expected_points[$];
  int unsigned total_items;
  int unsigned sent_count    = 0;
  int unsigned failures      = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  bit          pressure_done = 1'b0;

  // predicted line state
  logic [POS_W-1:0]      line_pos_x = '0;
  logic [POS_W-1:0]      line_pos_y = '0;
  logic [INC_W-1:0]      line_inc_x = '0;
  logic [INC_W-1:0]      line_inc_y = '0;
  logic [COORD_BITS:0]   line_steps_left = '0;
  logic                  line_active = 1'b0;

  dda_line_rasterizer #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always #1 clk = ~clk;

  function automatic logic [COORD_BITS:0] coord_span(coord_t origin, coord_t target);
    return (target < origin) ? {1'b0, coord_t'(origin - target)}
                             : {1'b0, coord_t'(target - origin)};
  endfunction

  // signed per-step increment, truncated toward zero
  function automatic logic [INC_W-1:0] axis_increment(coord_t origin, coord_t target,
                                                      logic [COORD_BITS:0] steps);
    logic [POS_W:0]   quo;
    logic [INC_W-1:0] inc;
    quo = {coord_span(origin, target), {FRAC_BITS{1'b0}}} / steps;
    inc = quo[INC_W-1:0];
    if (target < origin) begin
      inc = ~inc + 1'b1;
    end
    return inc;
  endfunction

  task automatic rasterise(dda_in_t req);
    logic [COORD_BITS:0] span_x;
    logic [COORD_BITS:0] span_y;
    logic [COORD_BITS:0] steps;
    dda_out_t            pt;
    if (req.kind == KIND_START) begin
      span_x     = coord_span(req.start_x, req.end_x);
      span_y     = coord_span(req.start_y, req.end_y);
      steps      = (span_x > span_y) ? span_x : span_y;
      line_pos_x = {req.start_x, {FRAC_BITS{1'b0}}};
      line_pos_y = {req.start_y, {FRAC_BITS{1'b0}}};
      if (steps == 0) begin
        line_inc_x  = '0;
        line_inc_y  = '0;
        line_active = 1'b0;
      end else begin
        line_inc_x  = axis_increment(req.start_x, req.end_x, steps);
        line_inc_y  = axis_increment(req.start_y, req.end_y, steps);
        line_active = 1'b1;
      end
      line_steps_left = steps;
    end else if (line_active) begin
      line_pos_x = line_pos_x + {{(POS_W-INC_W){line_inc_x[INC_W-1]}}, line_inc_x};
      line_pos_y = line_pos_y + {{(POS_W-INC_W){line_inc_y[INC_W-1]}}, line_inc_y};
      line_steps_left = line_steps_left - 1'b1;
      if (line_steps_left == 0) begin
        line_active = 1'b0;
      end
    end else begin
      // tick while idle: no pixel
      return;
    end
    pt.point_x    = line_pos_x[POS_W-1:FRAC_BITS];
    pt.point_y    = line_pos_y[POS_W-1:FRAC_BITS];
    pt.last_point = ~line_active;
    expected_points.push_back(pt);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  task automatic queue_line(int sx, int sy, int ex, int ey);
    dda_in_t req;
    req.kind    = KIND_START;
    req.start_x = coord_t'(sx);
    req.start_y = coord_t'(sy);
    req.end_x   = coord_t'(ex);
    req.end_y   = coord_t'(ey);
    pending_requests.push_back(req);
  endtask

  task automatic queue_ticks(int n);
    dda_in_t req;
    for (int i = 0; i < n; i++) begin
      req.kind    = KIND_TICK;
      req.start_x = coord_t'($urandom);
      req.start_y = coord_t'($urandom);
      req.end_x   = coord_t'($urandom);
      req.end_y   = coord_t'($urandom);
      pending_requests.push_back(req);
    end
  endtask

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && sent_count < total_items * 85 / 100 &&
            $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 16);
        end
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_req   <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // point receiver with random stalls and one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_left == 0) begin
        if (!pressure_done && sent_count >= total_items / 3) begin
          hold_left     = BACKPRESSURE_CYCLES;
          pressure_done = 1'b1;
        end else if (sent_count < total_items * 85 / 100 && $urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(1, 16);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare returned points, then predict from the request taken at this edge
  always @(posedge clk) begin
    dda_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point (%0d, %0d) last_point %0b",
                 out_rsp.point_x, out_rsp.point_y, out_rsp.last_point);
          failures++;
        end else begin
          want = expected_points.pop_front();
          if (out_rsp.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, out_rsp.point_x);
            failures++;
          end
          if (out_rsp.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, out_rsp.point_y);
            failures++;
          end
          if (out_rsp.last_point !== want.last_point) begin
            $error("last_point: expected %0b, got %0b", want.last_point, out_rsp.last_point);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        rasterise(in_req);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("no request or point moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sx;
    int sy;
    int ex;
    int ey;
    int span;
    int r;

    // directed lines
    queue_ticks(1);
    queue_line(0, 0, 0, 0);
    queue_ticks(1);
    queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_line(0, 0, 3, 1);
    queue_ticks(4);
    queue_line(COORD_MAX, 0, 0, COORD_MAX);
    queue_ticks(2);
    queue_line(5, 10, 5, 6);
    queue_ticks(4);
    queue_line(COORD_MAX, COORD_MAX, COORD_MAX - 6, COORD_MAX - 3);
    queue_ticks(6);

    // random lines, mostly short and run to completion
    while (pending_requests.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        queue_line(sx, sy, sx, sy);
      end else if (r == 1) begin
        queue_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        queue_ticks($urandom_range(0, 8));
      end else if (r == 2) begin
        queue_ticks($urandom_range(1, 3));
      end else begin
        sx   = $urandom_range(0, COORD_MAX);
        sy   = $urandom_range(0, COORD_MAX);
        ex   = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
        ey   = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
        span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > span) begin
          span = (ey > sy) ? ey - sy : sy - ey;
        end
        queue_line(sx, sy, ex, ey);
        if (r == 3) begin
          // abandon part way
          queue_ticks($urandom_range(0, span));
        end else begin
          // overrun by one tick now and then
          queue_ticks(span + ((r == 4) ? 1 : 0));
        end
      end
    end
    total_items = pending_requests.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_items || expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
